// File: rtl/core/hs_pkg.sv
// Shared types and constants for the heap_sort block.
// Depends on nothing; used by hs_cell, hs_ctrl and heap_sort.
`timescale 1ns / 1ps

package hs_pkg;

	localparam int MAX_ITEMS   = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(MAX_ITEMS + 1);

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		value_t value_in;
		logic   last_in;
	} in_t;

	typedef struct packed {
		value_t value_out;
		logic   last_out;
	} out_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctrl_t;

	function automatic logic value_lt(input value_t a, input value_t b);
		return a < b;
	endfunction

endpackage

// File: rtl/core/hs_cell.sv
// One cell of the sorting chain: holds a value and its valid bit.
// Depends on hs_pkg.
`timescale 1ns / 1ps

module hs_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  hs_pkg::cell_ctrl_t ctrl,
	input  hs_pkg::value_t     new_val,
	input  logic               prev_lt,
	input  hs_pkg::value_t     prev_val,
	input  logic               prev_vld,
	input  hs_pkg::value_t     next_val,
	input  logic               next_vld,
	output hs_pkg::value_t     val,
	output logic               vld,
	output logic               lt
);

	hs_pkg::value_t val_q;
	logic           vld_q;

	// an empty cell counts as larger than anything
	assign lt  = !vld_q || hs_pkg::value_lt(new_val, val_q);
	assign val = val_q;
	assign vld = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.shift) begin
			vld_q <= next_vld;
		end else if (ctrl.ins && lt) begin
			vld_q <= prev_lt ? prev_vld : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q <= next_val;
		end else if (ctrl.ins && lt) begin
			// displaced: take the neighbour's old value, else the new one lands here
			val_q <= prev_lt ? prev_val : new_val;
		end
	end

endmodule

// File: rtl/core/hs_ctrl.sv
// Sequencer for the heap_sort chain: fill count, load and drain phases.
// Depends on hs_pkg.
`timescale 1ns / 1ps

module hs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               last_in,
	output logic               busy,
	output logic               done,
	output logic               last_out,
	output hs_pkg::cell_ctrl_t ctrl
);

	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t      state_q;
	hs_pkg::cnt_t cnt_q;
	logic        accept;
	logic        room;

	assign accept     = start && (state_q == ST_LOAD);
	assign room       = cnt_q < hs_pkg::CNT_W'(hs_pkg::MAX_ITEMS);
	assign busy       = (state_q == ST_DRAIN);
	assign done       = (state_q == ST_DRAIN);
	assign last_out   = (cnt_q == hs_pkg::CNT_W'(1));
	assign ctrl.ins   = accept && room;
	assign ctrl.shift = (state_q == ST_DRAIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (room) cnt_q <= cnt_q + hs_pkg::CNT_W'(1);
						if (last_in) state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					cnt_q <= cnt_q - hs_pkg::CNT_W'(1);
					if (last_out) state_q <= ST_LOAD;
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/heap_sort.sv
// Top level of the heap_sort block: sequencer plus a chain of sorting cells.
// Depends on hs_pkg, hs_cell and hs_ctrl.
`timescale 1ns / 1ps

// Values are loaded one request per cycle while busy is low, each put into its
// sorted place in a chain of MAX_ITEMS cells as it arrives (one compare per
// cell against the incoming value, then a step along the chain). Requests
// beyond MAX_ITEMS are dropped, but a last request still ends the set. From
// the cycle after the request marked last, busy is high and the n stored
// values come out in ascending order, one per cycle on consecutive cycles
// with done high, the final one with last_out set; busy drops after that
// cycle. The receiver cannot hold results off, so it must take one result
// every cycle.
module heap_sort (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  hs_pkg::in_t request,
	output logic        done,
	output hs_pkg::out_t result
);

	hs_pkg::cell_ctrl_t ctrl;
	logic               last_out;
	hs_pkg::value_t     val [hs_pkg::MAX_ITEMS];
	logic               vld [hs_pkg::MAX_ITEMS];
	logic               lt  [hs_pkg::MAX_ITEMS];

	hs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.last_in  (request.last_in),
		.busy     (busy),
		.done     (done),
		.last_out (last_out),
		.ctrl     (ctrl)
	);

	for (genvar i = 0; i < hs_pkg::MAX_ITEMS; i++) begin : g_cell
		logic           p_lt;
		hs_pkg::value_t p_val;
		logic           p_vld;
		hs_pkg::value_t n_val;
		logic           n_vld;

		if (i == 0) begin : g_head
			assign p_lt  = 1'b0;
			assign p_val = request.value_in;
			assign p_vld = 1'b0;
		end else begin : g_body
			assign p_lt  = lt[i-1];
			assign p_val = val[i-1];
			assign p_vld = vld[i-1];
		end

		if (i == hs_pkg::MAX_ITEMS - 1) begin : g_tail
			assign n_val = val[i];
			assign n_vld = 1'b0;
		end else begin : g_mid
			assign n_val = val[i+1];
			assign n_vld = vld[i+1];
		end

		hs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.new_val  (request.value_in),
			.prev_lt  (p_lt),
			.prev_val (p_val),
			.prev_vld (p_vld),
			.next_val (n_val),
			.next_vld (n_vld),
			.val      (val[i]),
			.vld      (vld[i]),
			.lt       (lt[i])
		);
	end

	assign result.value_out = val[0];
	assign result.last_out  = last_out;

	// every drained result comes from a filled cell
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> vld[0])
		else $error("result taken from an empty cell");

	// the final result ends the drain and empties the chain
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.last_out |=> !busy && !vld[0])
		else $error("drain did not end after final result");

	// drain starts only from an accepted last request
	a_drain_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start) && $past(request.last_in))
		else $error("drain started without a last request");

	// insert and shift never overlap
	a_ctrl_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.ins && ctrl.shift))
		else $error("insert and shift in the same cycle");

endmodule

// File: tb/tb.sv
// Self-checking testbench for heap_sort: directed rows, then random sets of values.
// Depends on hs_pkg and the heap_sort RTL; predicts each sorted run and checks every result.
`timescale 1ns / 1ps

module tb;

	import hs_pkg::*;

	localparam int STALL_LIMIT  = 500;
	localparam int RANDOM_ITEMS = 240;
	localparam int TAIL_CYCLES  = MAX_ITEMS + 8;

	localparam value_t V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam value_t V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	// directed row; want is only meaningful for single-value sets (typed = 1)
	typedef struct packed {
		value_t value;
		logic   last;
		logic   typed;
		value_t want;
	} sort_row_t;

	localparam int N_ROWS = 20;
	localparam sort_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{32'sd0,   1'b1, 1'b1, 32'sd0},
		'{V_MAX,    1'b1, 1'b1, V_MAX},
		'{V_MIN,    1'b1, 1'b1, V_MIN},
		'{-32'sd1,  1'b1, 1'b1, -32'sd1},
		'{V_MAX,    1'b0, 1'b0, 32'sd0},
		'{V_MIN,    1'b0, 1'b0, 32'sd0},
		'{32'sd0,   1'b0, 1'b0, 32'sd0},
		'{-32'sd1,  1'b0, 1'b0, 32'sd0},
		'{32'sd1,   1'b1, 1'b0, 32'sd0},
		'{32'sd7,   1'b0, 1'b0, 32'sd0},
		'{32'sd7,   1'b0, 1'b0, 32'sd0},
		'{-32'sd7,  1'b0, 1'b0, 32'sd0},
		'{32'sd7,   1'b1, 1'b0, 32'sd0},
		'{-32'sd5,  1'b0, 1'b0, 32'sd0},
		'{32'sd0,   1'b0, 1'b0, 32'sd0},
		'{32'sd5,   1'b1, 1'b0, 32'sd0},
		'{32'sd40,  1'b0, 1'b0, 32'sd0},
		'{32'sd30,  1'b0, 1'b0, 32'sd0},
		'{32'sd20,  1'b0, 1'b0, 32'sd0},
		'{32'sd10,  1'b1, 1'b0, 32'sd0}
	};

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	in_t    request;
	logic   done;
	out_t   result;

	// travels alongside the request so the monitor sees the matching row
	logic   row_typed;
	value_t row_want;

	value_t held [$];
	out_t   due_results [$];
	bit     set_overfilled;

	int errors;
	int stall_cycles;
	int items_sent;
	int sets_sorted;
	int results_seen;
	int overfilled_sets;
	int dropped_values;

	heap_sort DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string what, input value_t want, input value_t got);
		errors++;
		$display("tb: mismatch on %s at %0t: want %0d got %0d", what, $realtime, want, got);
	endtask

	// Load one request into the model store; on a last request sort it and queue the run.
	task automatic take_request(input in_t r);
		value_t v;
		out_t   o;
		int     i;
		int     j;
		if (held.size() < MAX_ITEMS) begin
			held.push_back(r.value_in);
		end else begin
			dropped_values++;
			set_overfilled = 1'b1;
		end
		if (r.last_in) begin
			for (i = 1; i < held.size(); i++) begin
				v = held[i];
				j = i;
				while (j > 0 && held[j-1] > v) begin
					held[j] = held[j-1];
					j--;
				end
				held[j] = v;
			end
			if (row_typed) begin
				o.value_out = row_want;
				o.last_out  = 1'b1;
				due_results.push_back(o);
			end else begin
				for (i = 0; i < held.size(); i++) begin
					o.value_out = held[i];
					o.last_out  = (i == held.size() - 1);
					due_results.push_back(o);
				end
			end
			sets_sorted++;
			if (set_overfilled)
				overfilled_sets++;
			set_overfilled = 1'b0;
			held.delete();
		end
	endtask

	task automatic check_result(input out_t got);
		out_t want;
		results_seen++;
		if (due_results.size() == 0) begin
			report_mismatch("unexpected result", 32'sd0, got.value_out);
		end else begin
			want = due_results.pop_front();
			if (got.value_out !== want.value_out)
				report_mismatch("value_out", want.value_out, got.value_out);
			if (got.last_out !== want.last_out)
				report_mismatch("last_out", value_t'(want.last_out), value_t'(got.last_out));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				check_result(result);
			if (start && !busy)
				take_request(request);
			if (done || (start && !busy))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("tb: errors");
		$finish;
	end

	function automatic value_t pick_value();
		case ($urandom_range(0, 9))
			0: return V_MAX;
			1: return V_MIN;
			2, 3: return value_t'($signed($urandom_range(0, 15)) - 8);
			default: return value_t'($urandom);
		endcase
	endfunction

	task automatic send_request(input value_t v, input logic l, input logic typed,
		input value_t want, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		request   <= '{value_in: v, last_in: l};
		row_typed <= typed;
		row_want  <= want;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// hold off until every queued result has come back
	task automatic wait_for_drain();
		start <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	initial begin
		int  set_no;
		int  set_len;
		int  k;
		int  random_sent;
		bit  burst;
		clk            = 1'b0;
		arst_n         = 1'b0;
		start          = 1'b0;
		request        = '0;
		row_typed      = 1'b0;
		row_want       = '0;
		set_overfilled = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < N_ROWS; k++)
			send_request(DIRECTED_ROWS[k].value, DIRECTED_ROWS[k].last,
				DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want, $urandom_range(0, 2) == 0);
		wait_for_drain();

		// first two sets fill the store exactly, then overflow it (last two values dropped)
		random_sent = 0;
		set_no      = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (set_no == 0)
				set_len = MAX_ITEMS;
			else if (set_no == 1)
				set_len = MAX_ITEMS + 2;
			else begin
				case ($urandom_range(0, 19))
					0: set_len = MAX_ITEMS;
					1: set_len = MAX_ITEMS + $urandom_range(1, 4);
					2, 3: set_len = 1;
					default: set_len = $urandom_range(2, 12);
				endcase
			end
			burst = ($urandom_range(0, 2) == 0);
			for (k = 0; k < set_len; k++)
				send_request(pick_value(), k == set_len - 1, 1'b0, '0, burst);
			random_sent += set_len;
			set_no++;
			if ($urandom_range(0, 3) == 0)
				wait_for_drain();
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("tb: sent %0d requests in %0d sets, checked %0d sorted results",
			items_sent, sets_sorted, results_seen);
		$display("tb: %0d sets overflowed the store, %0d values dropped",
			overfilled_sets, dropped_values);
		if (errors == 0 && due_results.size() == 0) begin
			$display("tb: clean");
		end else begin
			if (due_results.size() != 0)
				report_mismatch("results still due", value_t'(due_results.size()), 32'sd0);
			$display("tb: errors");
		end
		$finish;
	end

endmodule
